>>> src/fsr_pkg.sv
// Package with the types, constants and trie table of the format specifier recognizer.
`default_nettype none
package fsr_pkg;

  typedef enum logic [2:0] {
    PH_PLUS   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_PREC   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_TRIE   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_XLO  = 8'h78;
  localparam logic [7:0] CH_XUP  = 8'h58;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [3:0] DECIMAL_BASE = 4'd10;

  localparam logic [2:0] UNIT_BYTE = 3'd1;
  localparam logic [2:0] UNIT_HALF = 3'd2;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_UP   = 2'd2;

  typedef struct packed {
    logic [31:0] character;
    logic        char_present;
    logic        end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  type_code;
    logic [7:0]  spec_length;
    logic [15:0] precision_value;
    logic        precision_used;
    logic        precision_from_arg;
    logic        plus_shown;
    logic [1:0]  prefix_mode;
    logic [1:0]  radix_code;
    logic        digits_upper;
    logic [1:0]  exponent_mode;
    logic        bool_upper;
  } out_word_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [31:0] ch;
    logic        present;
    logic        last;
  } cls_word_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] next;
    logic [5:0] tcode;
    logic [2:0] len;
  } edge_t;

  function automatic edge_t mk(input logic [6:0] n, input logic [5:0] t,
                               input logic [2:0] l);
    edge_t e;
    e.hit = 1'b1;
    e.next = n;
    e.tcode = t;
    e.len = l;
    return e;
  endfunction

  function automatic edge_t trie_edge(input logic [6:0] s, input logic [7:0] c);
    edge_t e;
    e = '0;
    unique case (s)
      7'd0: begin
        unique case (c)
          "e": e = mk(1, 1, 1);   "E": e = mk(3, 1, 1);   "f": e = mk(5, 1, 1);
          "d": e = mk(9, 2, 1);   "l": e = mk(35, 3, 1);  "b": e = mk(9, 4, 1);
          "o": e = mk(9, 0, 0);   "h": e = mk(9, 0, 0);   "H": e = mk(9, 0, 0);
          "s": e = mk(39, 5, 1);  "i": e = mk(44, 6, 1);  "u": e = mk(48, 7, 1);
          "m": e = mk(0, 8, 1);   "p": e = mk(0, 9, 1);   "Z": e = mk(0, 10, 1);
          "D": e = mk(0, 11, 1);  "z": e = mk(41, 12, 1); "c": e = mk(60, 13, 1);
          "B": e = mk(0, 4, 1);   "v": e = mk(65, 0, 0);  CH_BANG: e = mk(0, 14, 1);
          default: e = '0;
        endcase
      end
      7'd1, 7'd3: begin
        unique case (c)
          "f": e = mk(0, 1, 2);
          "l": e = mk(s + 7'd1, 0, 0);
          "d": e = mk(0, 2, 2);
          default: e = '0;
        endcase
      end
      7'd2, 7'd4: if (c == "d") e = mk(0, 15, 3);
      7'd5: begin
        unique case (c)
          "8": e = mk(0, 16, 2); "1": e = mk(6, 0, 0);
          "3": e = mk(7, 0, 0);  "6": e = mk(8, 0, 0);
          default: e = '0;
        endcase
      end
      7'd6: if (c == "6") e = mk(0, 17, 3);
      7'd7: if (c == "2") e = mk(0, 18, 3);
      7'd8: if (c == "4") e = mk(0, 19, 3);
      7'd9: begin
        unique case (c)
          "s": e = mk(10, 5, 2); "u": e = mk(11, 7, 2); "i": e = mk(23, 6, 2);
          "l": e = mk(27, 3, 2); "f": e = mk(31, 0, 0); "m": e = mk(0, 8, 2);
          "p": e = mk(0, 9, 2);  "Z": e = mk(0, 10, 2); "D": e = mk(0, 11, 2);
          default: e = '0;
        endcase
      end
      7'd10: if (c == "c") e = mk(0, 20, 3);
      7'd11: begin
        unique case (c)
          "s": e = mk(0, 21, 3); "l": e = mk(12, 22, 3); "8": e = mk(0, 23, 3);
          "1": e = mk(16, 0, 0); "3": e = mk(17, 0, 0);  "6": e = mk(18, 0, 0);
          "f": e = mk(19, 0, 0); "m": e = mk(0, 24, 3);  "p": e = mk(0, 25, 3);
          "c": e = mk(0, 26, 3);
          default: e = '0;
        endcase
      end
      7'd12: begin
        unique case (c)
          "l": e = mk(0, 27, 4); "8": e = mk(0, 28, 4); "1": e = mk(13, 0, 0);
          "3": e = mk(14, 0, 0); "6": e = mk(15, 0, 0);
          default: e = '0;
        endcase
      end
      7'd13: if (c == "6") e = mk(0, 29, 5);
      7'd14: if (c == "2") e = mk(0, 30, 5);
      7'd15: if (c == "4") e = mk(0, 31, 5);
      7'd16: if (c == "6") e = mk(0, 32, 4);
      7'd17: if (c == "2") e = mk(0, 33, 4);
      7'd18: if (c == "4") e = mk(0, 34, 4);
      7'd19: begin
        unique case (c)
          "8": e = mk(0, 35, 4); "1": e = mk(20, 0, 0);
          "3": e = mk(21, 0, 0); "6": e = mk(22, 0, 0);
          default: e = '0;
        endcase
      end
      7'd20: if (c == "6") e = mk(0, 36, 5);
      7'd21: if (c == "2") e = mk(0, 37, 5);
      7'd22: if (c == "4") e = mk(0, 38, 5);
      7'd23: begin
        unique case (c)
          "8": e = mk(0, 39, 3); "1": e = mk(24, 0, 0);
          "3": e = mk(25, 0, 0); "6": e = mk(26, 0, 0);
          default: e = '0;
        endcase
      end
      7'd24: if (c == "6") e = mk(0, 40, 4);
      7'd25: if (c == "2") e = mk(0, 41, 4);
      7'd26: if (c == "4") e = mk(0, 42, 4);
      7'd27: begin
        unique case (c)
          "l": e = mk(0, 43, 3); "8": e = mk(0, 44, 3); "1": e = mk(28, 0, 0);
          "3": e = mk(29, 0, 0); "6": e = mk(30, 0, 0);
          default: e = '0;
        endcase
      end
      7'd28: if (c == "6") e = mk(0, 45, 4);
      7'd29: if (c == "2") e = mk(0, 46, 4);
      7'd30: if (c == "4") e = mk(0, 47, 4);
      7'd31: begin
        unique case (c)
          "8": e = mk(0, 16, 3); "1": e = mk(32, 0, 0);
          "3": e = mk(33, 0, 0); "6": e = mk(34, 0, 0);
          default: e = '0;
        endcase
      end
      7'd32: if (c == "6") e = mk(0, 17, 4);
      7'd33: if (c == "2") e = mk(0, 18, 4);
      7'd34: if (c == "4") e = mk(0, 19, 4);
      7'd35: begin
        unique case (c)
          "l": e = mk(0, 43, 2); "d": e = mk(0, 15, 2); "8": e = mk(0, 44, 2);
          "1": e = mk(36, 0, 0); "3": e = mk(37, 0, 0); "6": e = mk(38, 0, 0);
          default: e = '0;
        endcase
      end
      7'd36: if (c == "6") e = mk(0, 45, 3);
      7'd37: if (c == "2") e = mk(0, 46, 3);
      7'd38: if (c == "4") e = mk(0, 47, 3);
      7'd39: begin
        if (c == "c") e = mk(0, 20, 2);
        else if (c == "3") e = mk(40, 0, 0);
      end
      7'd40: if (c == "2") e = mk(0, 48, 3);
      7'd41: begin
        unique case (c)
          "8": e = mk(0, 49, 2); "1": e = mk(42, 0, 0); "3": e = mk(43, 0, 0);
          default: e = '0;
        endcase
      end
      7'd42: if (c == "6") e = mk(0, 50, 3);
      7'd43: if (c == "2") e = mk(0, 51, 3);
      7'd44: begin
        unique case (c)
          "8": e = mk(0, 39, 2); "1": e = mk(45, 0, 0);
          "3": e = mk(46, 0, 0); "6": e = mk(47, 0, 0);
          default: e = '0;
        endcase
      end
      7'd45: if (c == "6") e = mk(0, 40, 3);
      7'd46: if (c == "2") e = mk(0, 41, 3);
      7'd47: if (c == "4") e = mk(0, 42, 3);
      7'd48: begin
        unique case (c)
          "s": e = mk(0, 21, 2); "l": e = mk(49, 22, 2); "8": e = mk(0, 23, 2);
          "1": e = mk(53, 0, 0); "3": e = mk(54, 0, 0);  "6": e = mk(55, 0, 0);
          "f": e = mk(56, 0, 0); "m": e = mk(0, 24, 2);  "p": e = mk(0, 25, 2);
          "c": e = mk(0, 26, 2);
          default: e = '0;
        endcase
      end
      7'd49: begin
        unique case (c)
          "l": e = mk(0, 27, 3); "8": e = mk(0, 28, 3); "1": e = mk(50, 0, 0);
          "3": e = mk(51, 0, 0); "6": e = mk(52, 0, 0);
          default: e = '0;
        endcase
      end
      7'd50: if (c == "6") e = mk(0, 29, 4);
      7'd51: if (c == "2") e = mk(0, 30, 4);
      7'd52: if (c == "4") e = mk(0, 31, 4);
      7'd53: if (c == "6") e = mk(0, 32, 3);
      7'd54: if (c == "2") e = mk(0, 33, 3);
      7'd55: if (c == "4") e = mk(0, 34, 3);
      7'd56: begin
        unique case (c)
          "8": e = mk(0, 35, 3); "1": e = mk(57, 0, 0);
          "3": e = mk(58, 0, 0); "6": e = mk(59, 0, 0);
          default: e = '0;
        endcase
      end
      7'd57: if (c == "6") e = mk(0, 36, 4);
      7'd58: if (c == "2") e = mk(0, 37, 4);
      7'd59: if (c == "4") e = mk(0, 38, 4);
      7'd60: begin
        unique case (c)
          "8": e = mk(0, 52, 2); "1": e = mk(61, 0, 0);
          "3": e = mk(62, 0, 0); "v": e = mk(63, 0, 0);
          default: e = '0;
        endcase
      end
      7'd61: if (c == "6") e = mk(0, 53, 3);
      7'd62: if (c == "2") e = mk(0, 54, 3);
      7'd63: if (c == "3") e = mk(64, 0, 0);
      7'd64: if (c == "2") e = mk(0, 55, 4);
      7'd65: if (c == "3") e = mk(66, 0, 0);
      7'd66: if (c == "2") e = mk(0, 56, 3);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

>>> src/fsr_if.sv
// Valid/ready channel interface carrying one word of a given type.
`default_nettype none
interface fsr_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/format_specifier_recognizer.sv
// Top level of the format specifier recognizer.
// One character word is taken per cycle while the two-entry queue has room; the
// queue separates the input masking from the recognizer, whose grammar step is a
// trie lookup and a multiply by ten for the precision. The word that ends a
// specifier passes through the queue, and its report is then held in an output
// register while the characters of the next specifier keep flowing; only the word
// that ends the next specifier stalls until the report has been taken.
`default_nettype none
module format_specifier_recognizer #(
  parameter int PRECISION_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_wdata,
  fsr_if.sink   in_ch,
  fsr_if.source out_ch
);
  import fsr_pkg::*;

  logic [2:0] unit_r;
  cls_word_t  qw;
  logic       qv, qr;

  always_ff @(posedge clk) begin
    if (!rst_n) unit_r <= UNIT_BYTE;
    else if (cfg_we) unit_r <= cfg_wdata;
  end

  fsr_front u_front (
    .clk(clk), .rst_n(rst_n), .unit_size(unit_r),
    .in_word(in_ch.data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .q_word(qw), .q_valid(qv), .q_ready(qr)
  );

  fsr_back #(.PRECISION_BITS(PRECISION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_word(qw), .q_valid(qv), .q_ready(qr),
    .out_word(out_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );
endmodule
`default_nettype wire

>>> src/fsr_front.sv
// Front part: accepts characters, masks them to the code unit size, queues them.
`default_nettype none
module fsr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [2:0]        unit_size,
  input  wire fsr_pkg::in_word_t in_word,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output fsr_pkg::cls_word_t     q_word,
  output logic                   q_valid,
  input  wire logic              q_ready
);
  import fsr_pkg::*;

  // Two-entry queue.
  cls_word_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cls_word_t  cw;
  logic       push, pop;

  always_comb begin
    cw.ch = in_word.character;
    if (unit_size == UNIT_BYTE) cw.ch = {24'd0, in_word.character[7:0]};
    else if (unit_size == UNIT_HALF) cw.ch = {16'd0, in_word.character[15:0]};
    cw.present = in_word.char_present;
    cw.last = in_word.end_of_string;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_word = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> src/fsr_back.sv
// Back part: runs the specifier grammar and the trie, and registers the report.
`default_nettype none
module fsr_back #(
  parameter int PRECISION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fsr_pkg::cls_word_t q_word,
  input  wire logic               q_valid,
  output logic                    q_ready,
  output fsr_pkg::out_word_t      out_word,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import fsr_pkg::*;

  localparam int PB = PRECISION_BITS;
  localparam logic [PB-1:0] PMAX = {PB{1'b1}};

  phase_t        phase_r, phase_nxt;
  logic [6:0]    trie_r, trie_nxt;
  logic [PB-1:0] acc_r, acc_nxt;
  logic [7:0]    pfx_r, pfx_nxt;
  logic [5:0]    type_r, type_nxt;
  logic [2:0]    blen_r, blen_nxt;
  logic          plus_r, plus_nxt, hexup_r, hexup_nxt, boolup_r, boolup_nxt;
  logic          pused_r, pused_nxt, parg_r, parg_nxt;
  logic [1:0]    pmode_r, pmode_nxt, radix_r, radix_nxt, exp_r, exp_nxt;
  out_word_t     res_r, res;
  logic          res_v_r;
  logic          take;
  logic [31:0]   c;
  logic          digit, narrow;
  logic [7:0]    c8;
  logic [3:0]    dval;
  logic [PB+4:0] prod;
  edge_t         e;
  logic [8:0]    lsum;

  assign q_ready = !q_word.last || !res_v_r || out_ready;
  assign take = q_valid && q_ready;
  assign c = q_word.ch;
  assign narrow = (c[31:8] == 24'd0);
  assign c8 = c[7:0];
  assign digit = narrow && c8 >= CH_ZERO && c8 <= CH_NINE;
  assign dval = c8[3:0];
  assign prod = {5'd0, acc_r} * {{(PB+1){1'b0}}, DECIMAL_BASE} + {{(PB+1){1'b0}}, dval};
  assign e = narrow ? trie_edge(trie_r, c8) : edge_t'('0);

  always_comb begin
    phase_nxt = phase_r; trie_nxt = trie_r; acc_nxt = acc_r; pfx_nxt = pfx_r;
    type_nxt = type_r; blen_nxt = blen_r; plus_nxt = plus_r; hexup_nxt = hexup_r;
    boolup_nxt = boolup_r; pused_nxt = pused_r; parg_nxt = parg_r;
    pmode_nxt = pmode_r; radix_nxt = radix_r; exp_nxt = exp_r;
    if (q_word.present) begin
      priority if ((phase_r == PH_PLUS) && narrow && c8 == CH_PLUS) begin
        phase_nxt = PH_PREFIX; plus_nxt = 1'b1;
        if (pfx_r != 8'hFF) pfx_nxt = pfx_r + 8'd1;
      end else if ((phase_r == PH_PLUS || phase_r == PH_PREFIX) && narrow &&
                   (c8 == CH_XLO || c8 == CH_XUP)) begin
        phase_nxt = PH_PREC; pmode_nxt = (c8 == CH_XUP) ? MODE_UP : MODE_LOW;
        if (pfx_r != 8'hFF) pfx_nxt = pfx_r + 8'd1;
      end else if ((phase_r == PH_PLUS || phase_r == PH_PREFIX || phase_r == PH_PREC)
                   && narrow && c8 == CH_STAR) begin
        phase_nxt = PH_TRIE; pused_nxt = 1'b1; parg_nxt = 1'b1;
        if (pfx_r != 8'hFF) pfx_nxt = pfx_r + 8'd1;
      end else if (phase_r != PH_TRIE && phase_r != PH_DONE && digit) begin
        phase_nxt = PH_DIGITS; pused_nxt = 1'b1;
        acc_nxt = (prod > {5'd0, PMAX}) ? PMAX : prod[PB-1:0];
        if (pfx_r != 8'hFF) pfx_nxt = pfx_r + 8'd1;
      end else if (phase_r != PH_DONE) begin
        if (!e.hit) phase_nxt = PH_DONE;
        else begin
          if (trie_r == 7'd0) begin
            unique case (c8)
              "e": exp_nxt = exp_r | MODE_LOW;
              "E": exp_nxt = exp_r | MODE_UP;
              "b": radix_nxt = RADIX_BIN;
              "o": radix_nxt = RADIX_OCT;
              "h": radix_nxt = RADIX_HEX;
              "H": begin radix_nxt = RADIX_HEX; hexup_nxt = 1'b1; end
              "B": boolup_nxt = 1'b1;
              default: begin end
            endcase
          end
          if (e.tcode != 6'd0) type_nxt = e.tcode;
          if (e.len != 3'd0) blen_nxt = e.len;
          if (e.next == 7'd0) phase_nxt = PH_DONE;
          else begin
            trie_nxt = e.next; phase_nxt = PH_TRIE;
          end
        end
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_comb begin
    lsum = {6'd0, blen_nxt} + {1'b0, pfx_nxt};
    res.type_code = type_nxt;
    res.spec_length = (type_nxt == 6'd0) ? 8'd0 : (lsum[8] ? 8'hFF : lsum[7:0]);
    res.precision_value = 16'(acc_nxt);
    res.precision_used = pused_nxt;
    res.precision_from_arg = parg_nxt;
    res.plus_shown = plus_nxt;
    res.prefix_mode = pmode_nxt;
    res.radix_code = radix_nxt;
    res.digits_upper = hexup_nxt;
    res.exponent_mode = exp_nxt;
    res.bool_upper = boolup_nxt;
  end

  always_ff @(posedge clk) begin
    if (take && q_word.last) res_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && q_word.last)) begin
      phase_r <= PH_PLUS; trie_r <= '0; acc_r <= '0; pfx_r <= '0; type_r <= '0;
      blen_r <= '0; plus_r <= 1'b0; hexup_r <= 1'b0; boolup_r <= 1'b0;
      pused_r <= 1'b0; parg_r <= 1'b0; pmode_r <= MODE_NONE; radix_r <= RADIX_DEC;
      exp_r <= MODE_NONE;
    end else if (take) begin
      phase_r <= phase_nxt; trie_r <= trie_nxt; acc_r <= acc_nxt; pfx_r <= pfx_nxt;
      type_r <= type_nxt; blen_r <= blen_nxt; plus_r <= plus_nxt;
      hexup_r <= hexup_nxt; boolup_r <= boolup_nxt; pused_r <= pused_nxt;
      parg_r <= parg_nxt; pmode_r <= pmode_nxt; radix_r <= radix_nxt; exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_v_r <= 1'b0;
    else if (take && q_word.last) res_v_r <= 1'b1;
    else if (out_ready) res_v_r <= 1'b0;
  end

  assign out_valid = res_v_r;
  assign out_word = res_r;
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the format specifier recognizer.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import fsr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = 3'd1;

  fsr_if #(.word_t(in_word_t)) in_ch ();
  fsr_if #(.word_t(out_word_t)) out_ch ();

  format_specifier_recognizer uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [2:0] unit_size;
  phase_t sp_phase;
  logic [6:0] sp_node;
  logic [15:0] sp_prec;
  logic [7:0] sp_pfx;
  logic [5:0] sp_type;
  logic [2:0] sp_body;
  logic sp_plus, sp_pused, sp_parg, sp_hexup, sp_boolup;
  logic [1:0] sp_pmode, sp_radix, sp_exp;

  out_word_t pending_reports[$];
  int mismatches = 0;
  int reports_seen = 0;
  int words_sent = 0;
  int cycles = 0;
  bit rx_stall_on = 1'b1;
  bit tx_idle_on = 1'b1;
  int hold_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [6:0] node_next(input logic [6:0] s, input logic [7:0] c,
                                           output logic hit, output logic [5:0] t,
                                           output logic [2:0] l);
    logic [6:0] n;
    hit = 1'b1; t = 0; l = 0; n = 0;
    case (s)
      0: case (c)
        "e": begin n = 1; t = 1; l = 1; end
        "E": begin n = 3; t = 1; l = 1; end
        "f": begin n = 5; t = 1; l = 1; end
        "d": begin n = 9; t = 2; l = 1; end
        "l": begin n = 35; t = 3; l = 1; end
        "b": begin n = 9; t = 4; l = 1; end
        "o", "h", "H": n = 9;
        "s": begin n = 39; t = 5; l = 1; end
        "i": begin n = 44; t = 6; l = 1; end
        "u": begin n = 48; t = 7; l = 1; end
        "m": begin t = 8; l = 1; end
        "p": begin t = 9; l = 1; end
        "Z": begin t = 10; l = 1; end
        "D": begin t = 11; l = 1; end
        "z": begin n = 41; t = 12; l = 1; end
        "c": begin n = 60; t = 13; l = 1; end
        "B": begin t = 4; l = 1; end
        "v": n = 65;
        "!": begin t = 14; l = 1; end
        default: hit = 1'b0;
      endcase
      1, 3: case (c)
        "f": begin t = 1; l = 2; end
        "l": n = s + 1;
        "d": begin t = 2; l = 2; end
        default: hit = 1'b0;
      endcase
      2, 4: if (c == "d") begin t = 15; l = 3; end else hit = 1'b0;
      5, 31: case (c)
        "8": begin t = 16; l = (s == 5) ? 2 : 3; end
        "1": n = s + 1; "3": n = s + 2; "6": n = s + 3;
        default: hit = 1'b0;
      endcase
      6, 7, 8, 32, 33, 34: begin
        if (c == ((s == 6 || s == 32) ? "6" : (s == 7 || s == 33) ? "2" : "4")) begin
          t = (s < 32) ? s + 11 : s - 15; l = (s < 32) ? 3 : 4;
        end else hit = 1'b0;
      end
      9: case (c)
        "s": begin n = 10; t = 5; l = 2; end
        "u": begin n = 11; t = 7; l = 2; end
        "i": begin n = 23; t = 6; l = 2; end
        "l": begin n = 27; t = 3; l = 2; end
        "f": n = 31;
        "m": begin t = 8; l = 2; end
        "p": begin t = 9; l = 2; end
        "Z": begin t = 10; l = 2; end
        "D": begin t = 11; l = 2; end
        default: hit = 1'b0;
      endcase
      10: if (c == "c") begin t = 20; l = 3; end else hit = 1'b0;
      11, 48: case (c)
        "s": begin t = 21; l = (s == 11) ? 3 : 2; end
        "l": begin n = s + 1; t = 22; l = (s == 11) ? 3 : 2; end
        "8": begin t = 23; l = (s == 11) ? 3 : 2; end
        "1": n = (s == 11) ? 16 : 53;
        "3": n = (s == 11) ? 17 : 54;
        "6": n = (s == 11) ? 18 : 55;
        "f": n = (s == 11) ? 19 : 56;
        "m": begin t = 24; l = (s == 11) ? 3 : 2; end
        "p": begin t = 25; l = (s == 11) ? 3 : 2; end
        "c": begin t = 26; l = (s == 11) ? 3 : 2; end
        default: hit = 1'b0;
      endcase
      12, 49: case (c)
        "l": begin t = 27; l = (s == 12) ? 4 : 3; end
        "8": begin t = 28; l = (s == 12) ? 4 : 3; end
        "1": n = s + 1; "3": n = s + 2; "6": n = s + 3;
        default: hit = 1'b0;
      endcase
      19, 56: case (c)
        "8": begin t = 35; l = (s == 19) ? 4 : 3; end
        "1": n = s + 1; "3": n = s + 2; "6": n = s + 3;
        default: hit = 1'b0;
      endcase
      23, 44: case (c)
        "8": begin t = 39; l = (s == 23) ? 3 : 2; end
        "1": n = s + 1; "3": n = s + 2; "6": n = s + 3;
        default: hit = 1'b0;
      endcase
      27, 35: case (c)
        "l": begin t = 43; l = (s == 27) ? 3 : 2; end
        "d": if (s == 35) begin t = 15; l = 2; end else hit = 1'b0;
        "8": begin t = 44; l = (s == 27) ? 3 : 2; end
        "1": n = s + 1; "3": n = s + 2; "6": n = s + 3;
        default: hit = 1'b0;
      endcase
      13, 14, 15, 16, 17, 18, 20, 21, 22, 24, 25, 26, 28, 29, 30, 36, 37, 38,
      45, 46, 47, 50, 51, 52, 53, 54, 55, 57, 58, 59: begin
        logic [7:0] want;
        int k;
        k = (s == 13 || s == 16 || s == 20 || s == 24 || s == 28 || s == 36 ||
             s == 45 || s == 50 || s == 53 || s == 57) ? 0 :
            (s == 14 || s == 17 || s == 21 || s == 25 || s == 29 || s == 37 ||
             s == 46 || s == 51 || s == 54 || s == 58) ? 1 : 2;
        want = (k == 0) ? "6" : (k == 1) ? "2" : "4";
        if (c != want) hit = 1'b0;
        else case (s)
          13, 14, 15: begin t = s + 16; l = 5; end
          16, 17, 18: begin t = s + 16; l = 4; end
          20, 21, 22: begin t = s + 16; l = 5; end
          24, 25, 26: begin t = s + 16; l = 4; end
          28, 29, 30: begin t = s + 17; l = 4; end
          36, 37, 38: begin t = s + 9; l = 3; end
          45, 46, 47: begin t = s - 5; l = 3; end
          50, 51, 52: begin t = s - 21; l = 4; end
          53, 54, 55: begin t = s - 21; l = 3; end
          default: begin t = s - 21; l = 4; end
        endcase
      end
      39: if (c == "c") begin t = 20; l = 2; end
          else if (c == "3") n = 40; else hit = 1'b0;
      40: if (c == "2") begin t = 48; l = 3; end else hit = 1'b0;
      41: case (c)
        "8": begin t = 49; l = 2; end
        "1": n = 42; "3": n = 43;
        default: hit = 1'b0;
      endcase
      42: if (c == "6") begin t = 50; l = 3; end else hit = 1'b0;
      43: if (c == "2") begin t = 51; l = 3; end else hit = 1'b0;
      60: case (c)
        "8": begin t = 52; l = 2; end
        "1": n = 61; "3": n = 62; "v": n = 63;
        default: hit = 1'b0;
      endcase
      61: if (c == "6") begin t = 53; l = 3; end else hit = 1'b0;
      62: if (c == "2") begin t = 54; l = 3; end else hit = 1'b0;
      63: if (c == "3") n = 64; else hit = 1'b0;
      64: if (c == "2") begin t = 55; l = 4; end else hit = 1'b0;
      65: if (c == "3") n = 66; else hit = 1'b0;
      66: if (c == "2") begin t = 56; l = 3; end else hit = 1'b0;
      default: hit = 1'b0;
    endcase
    return n;
  endfunction

  task automatic clear_spec();
    sp_phase = PH_PLUS; sp_node = 0; sp_prec = 0; sp_pfx = 0; sp_type = 0;
    sp_body = 0; sp_plus = 0; sp_pused = 0; sp_parg = 0; sp_hexup = 0;
    sp_boolup = 0; sp_pmode = MODE_NONE; sp_radix = RADIX_DEC; sp_exp = MODE_NONE;
  endtask

  task automatic bump_prefix();
    if (sp_pfx != 8'hFF) sp_pfx = sp_pfx + 1;
  endtask

  task automatic add_precision_digit(input logic [31:0] c);
    logic [35:0] v;
    v = sp_prec * 10 + (c - CH_ZERO);
    sp_prec = (v > 36'hFFFF) ? 16'hFFFF : v[15:0];
    sp_pused = 1'b1;
    bump_prefix();
  endtask

  task automatic walk_trie(input logic [31:0] c);
    logic hit;
    logic [5:0] t;
    logic [2:0] l;
    logic [6:0] n;
    n = node_next(sp_node, c[7:0], hit, t, l);
    if (!hit || c[31:8] != 0) begin
      sp_phase = PH_DONE;
      return;
    end
    if (sp_node == 0) begin
      case (c[7:0])
        "e": sp_exp = sp_exp | MODE_LOW;
        "E": sp_exp = sp_exp | MODE_UP;
        "b": sp_radix = RADIX_BIN;
        "o": sp_radix = RADIX_OCT;
        "h": sp_radix = RADIX_HEX;
        "H": begin sp_radix = RADIX_HEX; sp_hexup = 1'b1; end
        "B": sp_boolup = 1'b1;
        default: ;
      endcase
    end
    if (t != 0) sp_type = t;
    if (l != 0) sp_body = l;
    if (n == 0) sp_phase = PH_DONE;
    else sp_node = n;
  endtask

  task automatic take_character(input logic [31:0] c);
    logic digit;
    digit = (c >= CH_ZERO && c <= CH_NINE);
    if (sp_phase == PH_PLUS) begin
      sp_phase = PH_PREFIX;
      if (c == CH_PLUS) begin sp_plus = 1'b1; bump_prefix(); return; end
    end
    if (sp_phase == PH_PREFIX) begin
      sp_phase = PH_PREC;
      if (c == CH_XLO || c == CH_XUP) begin
        sp_pmode = sp_pmode | ((c == CH_XUP) ? MODE_UP : MODE_LOW);
        bump_prefix();
        return;
      end
    end
    if (sp_phase == PH_PREC) begin
      if (c == CH_STAR) begin
        sp_pused = 1'b1; sp_parg = 1'b1; bump_prefix(); sp_phase = PH_TRIE; return;
      end
      if (digit) begin add_precision_digit(c); sp_phase = PH_DIGITS; return; end
      sp_phase = PH_TRIE;
    end
    if (sp_phase == PH_DIGITS) begin
      if (digit) begin add_precision_digit(c); return; end
      sp_phase = PH_TRIE;
    end
    if (sp_phase == PH_TRIE) walk_trie(c);
  endtask

  task automatic predict_spec(input in_word_t w);
    logic [31:0] c;
    out_word_t r;
    int len;
    c = w.character;
    if (unit_size == UNIT_BYTE) c = c & 32'hFF;
    else if (unit_size == UNIT_HALF) c = c & 32'hFFFF;
    if (w.char_present) take_character(c);
    if (!w.end_of_string) return;
    len = (sp_type != 0) ? sp_body + sp_pfx : 0;
    r.type_code = sp_type;
    r.spec_length = (len > 255) ? 8'hFF : len[7:0];
    r.precision_value = sp_prec;
    r.precision_used = sp_pused;
    r.precision_from_arg = sp_parg;
    r.plus_shown = sp_plus;
    r.prefix_mode = sp_pmode;
    r.radix_code = sp_radix;
    r.digits_upper = sp_hexup;
    r.exponent_mode = sp_exp;
    r.bool_upper = sp_boolup;
    pending_reports.push_back(r);
    clear_spec();
  endtask

  // Receiver side: ready with random stalls, and a long hold-off on request.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 5) == 0)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      reports_seen <= reports_seen + 1;
      if (pending_reports.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS) $display("Unexpected word %h", out_ch.data);
      end else begin
        if (pending_reports[0] !== out_ch.data) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("Mismatch: expected %p actual %p", pending_reports[0], out_ch.data);
        end
        void'(pending_reports.pop_front());
      end
    end
  end

  task automatic send_char(input logic [31:0] c, input logic present, input logic last);
    in_word_t w;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    w.character = c; w.char_present = present; w.end_of_string = last;
    in_ch.data <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_spec(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b1, i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_unit_size(input logic [2:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    unit_size = v;
  endtask

  task automatic test_directed();
    send_text("d"); send_text("+x*ullint64"); send_text("X65535H");
    send_text("999999e"); send_text("Elf"); send_text("f32");
    send_text("ucv32"); send_text("uv32"); send_text("zu8"); send_text("!");
    send_text("Bq"); send_text("o*s32"); send_text("ulf64");
    send_char(0, 1'b0, 1'b1);
    send_char("d", 1'b0, 1'b0);
    send_char(32'hFFFF_FF64, 1'b1, 1'b1);
    send_text("q");
    send_text("huuuu");
  endtask

  task automatic test_long_prefix();
    for (int i = 0; i < 300; i++) send_char("7", 1'b1, 1'b0);
    send_text("ulf16");
  endtask

  function automatic logic [31:0] random_char(input bit wide);
    string pool;
    logic [31:0] c;
    pool = "+xX*0123456789eEfdlbohHsiumpZDzcBvq!8";
    if (wide || $urandom_range(0, 9) == 0) c = $urandom;
    else c = pool[$urandom_range(0, pool.len() - 1)];
    if ($urandom_range(0, 3) == 0) c[31:8] = $urandom;
    return c;
  endfunction

  task automatic test_random(input int count);
    string words[$] = '{"d", "ld", "lld", "elf", "Ed", "f16", "f64", "ds", "du",
      "dsc", "dus", "dul", "dull", "dul16", "duf32", "dif8", "di32", "dl64",
      "dfl", "ul32", "uf64", "sc", "s32", "z16", "c32", "cv32", "v32", "hp",
      "bZ", "oD", "Hm", "um", "up", "uc", "l8", "i16", "ul8"};
    int sent;
    string s;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        s = "";
        if ($urandom_range(0, 1)) s = {s, "+"};
        case ($urandom_range(0, 2)) 1: s = {s, "x"}; 2: s = {s, "X"}; default: ; endcase
        case ($urandom_range(0, 2))
          1: s = {s, "*"};
          2: repeat ($urandom_range(1, 6)) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
          default: ;
        endcase
        s = {s, words[$urandom_range(0, words.size() - 1)]};
        for (int i = 0; i < s.len(); i++) begin
          send_char(s[i] | ($urandom_range(0, 5) == 0 ? {$urandom, 8'h00} : 0),
                    1'b1, 1'b0);
          sent++;
        end
        repeat ($urandom_range(0, 2)) begin
          send_char(random_char(0), $urandom_range(0, 1), 1'b0);
          sent++;
        end
        send_char(random_char(0), $urandom_range(0, 3) != 0, 1'b1);
      end else begin
        repeat ($urandom_range(0, 6)) begin
          send_char(random_char(1), $urandom_range(0, 1), 1'b0);
          sent++;
        end
        send_char(random_char(1), $urandom_range(0, 1), 1'b1);
      end
      sent++;
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 60;
    for (int i = 0; i < 20; i++) send_text("d");
    wait_drained();
    send_text("+ul");
  endtask

  initial begin
    unit_size = UNIT_BYTE;
    clear_spec();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_long_prefix();
    set_unit_size(3'd2);
    test_random(400);
    test_backpressure();
    set_unit_size(3'd4);
    test_random(400);
    set_unit_size(3'd7);
    test_random(300);
    set_unit_size(3'd0);
    test_random(300);
    set_unit_size(3'd1);
    test_random(300);
    rx_stall_on = 1'b0;
    tx_idle_on = 1'b0;
    test_random(300);
    wait_drained();
    $display("Sent %0d words under five unit sizes; %0d reports checked, %0d mismatches.",
             words_sent, reports_seen, mismatches);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
